>>> src/sbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

  localparam int SBT_DEPTH  = 16;
  localparam int RESULT_CAP = 16;

  localparam int REQ_W  = 2;
  localparam int TICK_W = 32;
  localparam int SLOT_W = 4;
  localparam int STAT_W = 2;
  localparam int ATT_W  = 32;

  localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNAVAIL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADTIME = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_RMV,
    S_LIST,
    S_RESP
  } sbt_state_t;

endpackage

`default_nettype wire

>>> src/sbt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbt_in_if;
  import sbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TICK_W-1:0] tick_count;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output req_type, output tick_count, output slot_index,
                  input ready);
  modport sink (input valid, input req_type, input tick_count, input slot_index,
                output ready);
endinterface

`default_nettype wire

>>> src/sbt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbt_out_if;
  import sbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              entry_valid;
  logic [TICK_W-1:0] entry_time;
  logic [ATT_W-1:0]  entry_attempt;
  logic              last;

  modport source (output valid, output status, output entry_valid, output entry_time,
                  output entry_attempt, output last, input ready);
  modport sink (input valid, input status, input entry_valid, input entry_time,
                input entry_attempt, input last, output ready);
endinterface

`default_nettype wire

>>> src/sbt_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbt_cfg_if;
  logic valid;
  logic ready;
  logic stats_enabled;

  modport source (output valid, output stats_enabled, input ready);
  modport sink (input valid, input stats_enabled, output ready);
endinterface

`default_nettype wire

>>> src/sorted_best_times_table.sv
// record walks up from the last entry, moving each larger time down a slot (a full table
// drops its last), then writes; remove shifts later entries up; others go straight to reply
// list: one entry per cycle while the receiver keeps up, after a registered ram read, at most 16 items
// one request at a time, ready again the cycle after its last result is loaded
// reset: fill count, attempt counter and control cleared, stats enabled;
// table ram is not cleared, the fill count marks the valid prefix
`timescale 1ns / 1ps
`default_nettype none

module sorted_best_times_table #(
  parameter int TABLE_DEPTH = sbt_pkg::SBT_DEPTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sbt_in_if.sink    in_if,
  sbt_out_if.source out_if,
  sbt_cfg_if.sink   cfg_if
);
  import sbt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = TICK_W + ATT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  sbt_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ATT_W-1:0]  total_r, total_nxt;
  logic              en_r;
  logic [IDX_W-1:0]  c_r, c_nxt;
  logic [TICK_W-1:0] t_r, t_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] o_stat_r, o_stat_nxt;
  logic              o_valid_r, o_valid_nxt;
  logic [TICK_W-1:0] o_time_r, o_time_nxt;
  logic [ATT_W-1:0]  o_att_r, o_att_nxt;
  logic              o_last_r, o_last_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;
  logic [TICK_W-1:0] rd_time;
  logic [ATT_W-1:0]  rd_att;
  logic [ATT_W-1:0]  new_att;
  logic [CNT_W-1:0]  cnt_m1, rmv_next;
  logic              acc, out_free, o_load, commit;
  logic              rm_ok, list_last, ins_less, at_end, rmv_done;

  sbt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time   = rdata[ENT_W-1 -: TICK_W];
  assign rd_att    = rdata[ATT_W-1:0];
  assign new_att   = total_r + ATT_W'(1);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign rmv_next  = {1'b0, c_r} + CNT_W'(2);
  assign acc       = in_if.valid && in_if.ready;
  assign out_free  = !ov_r || out_if.ready;
  assign rm_ok     = 32'(in_if.slot_index) < 32'(cnt_r);
  assign list_last = ({1'b0, c_r} == cnt_m1) || (32'(c_r) == RESULT_CAP - 1);
  assign ins_less  = t_r < rd_time;
  assign at_end    = c_r == LAST_IDX;
  assign rmv_done  = rmv_next == cnt_r;

  assign in_if.ready  = state_r == S_IDLE;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid         = ov_r;
  assign out_if.status        = o_stat_r;
  assign out_if.entry_valid   = o_valid_r;
  assign out_if.entry_time    = o_time_r;
  assign out_if.entry_attempt = o_att_r;
  assign out_if.last          = o_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!en_r) begin
            state_nxt = S_RESP;
          end else if (in_if.req_type == REQ_RECORD) begin
            if (in_if.tick_count == '0) begin
              state_nxt = S_RESP;
            end else if (cnt_r == '0) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_INS;
            end
          end else if (in_if.req_type == REQ_REMOVE) begin
            if (rm_ok && (32'(in_if.slot_index) + 1 != 32'(cnt_r))) begin
              state_nxt = S_RMV;
            end else begin
              state_nxt = S_RESP;
            end
          end else if (in_if.req_type == REQ_LIST) begin
            state_nxt = (cnt_r == '0) ? S_RESP : S_LIST;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_INS: begin
        if (!ins_less || c_r == '0) begin
          state_nxt = (ins_less) ? S_PUT : S_RESP;
        end
      end
      S_PUT: state_nxt = S_RESP;
      S_RMV: begin
        if (rmv_done) begin
          state_nxt = S_RESP;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    c_nxt       = c_r;
    t_nxt       = t_r;
    stat_nxt    = stat_r;
    we          = 1'b0;
    waddr       = c_r + IDX_W'(1);
    wdata       = rdata;
    raddr       = c_r;
    commit      = 1'b0;
    o_load      = 1'b0;
    o_stat_nxt  = o_stat_r;
    o_valid_nxt = o_valid_r;
    o_time_nxt  = o_time_r;
    o_att_nxt   = o_att_r;
    o_last_nxt  = o_last_r;
    unique case (state_r)
      S_IDLE: begin
        t_nxt = in_if.tick_count;
        if (acc) begin
          stat_nxt = STAT_OK;
          if (!en_r) begin
            stat_nxt = STAT_UNAVAIL;
          end else if (in_if.req_type == REQ_RECORD) begin
            if (in_if.tick_count == '0) begin
              stat_nxt = STAT_BADTIME;
            end
            c_nxt = cnt_m1[IDX_W-1:0];
            raddr = cnt_m1[IDX_W-1:0];
          end else if (in_if.req_type == REQ_REMOVE) begin
            c_nxt = IDX_W'(in_if.slot_index);
            raddr = IDX_W'(in_if.slot_index) + IDX_W'(1);
            if (!rm_ok) begin
              stat_nxt = STAT_REJECT;
            end else if (32'(in_if.slot_index) + 1 == 32'(cnt_r)) begin
              cnt_nxt = cnt_m1;
            end
          end else if (in_if.req_type == REQ_LIST) begin
            c_nxt = '0;
            raddr = '0;
          end else begin
            stat_nxt = STAT_REJECT;
          end
        end
      end
      S_INS: begin
        if (ins_less) begin
          // shift this entry down, last one falls off
          we    = !at_end;
          c_nxt = c_r - IDX_W'(1);
          raddr = c_r - IDX_W'(1);
        end else if (at_end) begin
          stat_nxt = STAT_REJECT;
        end else begin
          we     = 1'b1;
          wdata  = {t_r, new_att};
          commit = 1'b1;
        end
      end
      S_PUT: begin
        we     = 1'b1;
        waddr  = '0;
        wdata  = {t_r, new_att};
        commit = 1'b1;
      end
      S_RMV: begin
        we    = 1'b1;
        waddr = c_r;
        c_nxt = c_r + IDX_W'(1);
        raddr = rmv_next[IDX_W-1:0];
        if (rmv_done) begin
          cnt_nxt = cnt_m1;
        end
      end
      S_LIST: begin
        if (out_free) begin
          o_load      = 1'b1;
          o_stat_nxt  = STAT_OK;
          o_valid_nxt = 1'b1;
          o_time_nxt  = rd_time;
          o_att_nxt   = rd_att;
          o_last_nxt  = list_last;
          c_nxt       = c_r + IDX_W'(1);
          raddr       = c_r + IDX_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          o_load      = 1'b1;
          o_stat_nxt  = stat_r;
          o_valid_nxt = 1'b0;
          o_time_nxt  = '0;
          o_att_nxt   = '0;
          o_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
    if (commit) begin
      total_nxt = new_att;
      if (cnt_r != DEPTH_C) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    ov_nxt = o_load ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
      en_r    <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        en_r <= cfg_if.stats_enabled;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    t_r       <= t_nxt;
    stat_r    <= stat_nxt;
    o_stat_r  <= o_stat_nxt;
    o_valid_r <= o_valid_nxt;
    o_time_r  <= o_time_nxt;
    o_att_r   <= o_att_nxt;
    o_last_r  <= o_last_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_INS || state_r == S_PUT || state_r == S_RMV))
    else $error("table write outside insert or remove");

  a_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && en_r && in_if.req_type == REQ_RECORD && in_if.tick_count == '0)
    |=> (state_r == S_RESP && stat_r == STAT_BADTIME))
    else $error("zero time not refused");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> total_r == $past(total_r) + ATT_W'(1))
    else $error("attempt counter did not step");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_valid_r) |-> o_stat_r == STAT_OK)
    else $error("listed entry with bad status");

endmodule

`default_nettype wire

>>> src/sbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> tb/sv/sorted_best_times_table_tb.sv
`timescale 1ns / 1ps

module sorted_best_times_table_tb;
  import sbt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int REPORT_MAX = 10;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              entry_valid;
    logic [TICK_W-1:0] entry_time;
    logic [ATT_W-1:0]  entry_attempt;
    logic              last;
  } reply_t;

  logic clk;
  logic rst_n;

  sbt_in_if  in_ch ();
  sbt_out_if out_ch ();
  sbt_cfg_if cfg_ch ();

  sorted_best_times_table #(
    .TABLE_DEPTH(SBT_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  logic [TICK_W-1:0] best_time    [SBT_DEPTH];
  logic [ATT_W-1:0]  best_attempt [SBT_DEPTH];
  logic [ATT_W-1:0]  attempt_count;
  logic              stats_on;
  reply_t            due_replies[$];

  int   bad_count;
  int   gap_pct;
  int   stall_pct;
  logic rx_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int filled_slots();
    int n;
    n = 0;
    while (n < SBT_DEPTH && best_time[n] != '0) n++;
    return n;
  endfunction

  function automatic void apply_request(logic [REQ_W-1:0] kind, logic [TICK_W-1:0] ticks,
                                        logic [SLOT_W-1:0] slot);
    reply_t r;
    int     pos;
    int     n;
    int     i;
    r = '{status: STAT_OK, entry_valid: 1'b0, entry_time: '0, entry_attempt: '0, last: 1'b1};
    pos = -1;
    n = 0;
    if (!stats_on) begin
      r.status = STAT_UNAVAIL;
    end else begin
      case (kind)
        REQ_RECORD: begin
          if (ticks == '0) begin
            r.status = STAT_BADTIME;
          end else begin
            for (i = 0; i < SBT_DEPTH; i++)
              if (pos < 0 && (best_time[i] == '0 || ticks < best_time[i])) pos = i;
            if (pos < 0) begin
              r.status = STAT_REJECT;
            end else begin
              for (i = SBT_DEPTH - 1; i > pos; i--) begin
                best_time[i] = best_time[i-1];
                best_attempt[i] = best_attempt[i-1];
              end
              attempt_count = attempt_count + 1;
              best_time[pos] = ticks;
              best_attempt[pos] = attempt_count;
            end
          end
        end
        REQ_REMOVE: begin
          if (int'(slot) >= SBT_DEPTH || best_time[slot] == '0) begin
            r.status = STAT_REJECT;
          end else begin
            for (i = int'(slot); i < SBT_DEPTH - 1; i++) begin
              best_time[i] = best_time[i+1];
              best_attempt[i] = best_attempt[i+1];
            end
            best_time[SBT_DEPTH-1] = '0;
            best_attempt[SBT_DEPTH-1] = '0;
          end
        end
        REQ_LIST: begin
          while (n < SBT_DEPTH && n < RESULT_CAP && best_time[n] != '0) n++;
          for (i = 0; i < n; i++)
            due_replies.push_back('{status: STAT_OK, entry_valid: 1'b1,
                                    entry_time: best_time[i], entry_attempt: best_attempt[i],
                                    last: (i == n - 1)});
        end
        default: r.status = STAT_REJECT;
      endcase
    end
    if (n == 0) due_replies.push_back(r);
  endfunction

  function automatic void note_bad(string what, logic [31:0] want, logic [31:0] got);
    if (bad_count < REPORT_MAX)
      $display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
    bad_count++;
  endfunction

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_replies.size() == 0) begin
        note_bad("unexpected item, status", '0, 32'(out_ch.status));
      end else begin
        want = due_replies.pop_front();
        if (out_ch.status !== want.status)
          note_bad("status", 32'(want.status), 32'(out_ch.status));
        if (out_ch.entry_valid !== want.entry_valid)
          note_bad("entry_valid", 32'(want.entry_valid), 32'(out_ch.entry_valid));
        if (out_ch.entry_time !== want.entry_time)
          note_bad("entry_time", want.entry_time, out_ch.entry_time);
        if (out_ch.entry_attempt !== want.entry_attempt)
          note_bad("entry_attempt", want.entry_attempt, out_ch.entry_attempt);
        if (out_ch.last !== want.last) note_bad("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [TICK_W-1:0] ticks,
                              input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.tick_count <= ticks;
    in_ch.slot_index <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_request(kind, ticks, slot);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stats(input logic enable);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.stats_enabled <= enable;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    stats_on = enable;
  endtask

  task automatic send_random();
    int                pick;
    int                sel;
    int                fill;
    logic [TICK_W-1:0] ticks;
    logic [SLOT_W-1:0] slot;
    pick  = $urandom_range(99);
    sel   = $urandom_range(19);
    fill  = filled_slots();
    ticks = $urandom;
    slot  = SLOT_W'($urandom_range(SBT_DEPTH - 1));
    if (pick < 45) begin
      if (sel == 0) ticks = '0;
      else if (sel <= 3 && fill > 0) ticks = best_time[$urandom_range(fill - 1)];
      else if (sel <= 11) ticks = $urandom_range(1000, 1);
      send_request(REQ_RECORD, ticks, slot);
    end else if (pick < 70) begin
      if (fill > 0 && $urandom_range(3) != 0) slot = SLOT_W'($urandom_range(fill - 1));
      send_request(REQ_REMOVE, ticks, slot);
    end else if (pick < 93) begin
      send_request(REQ_LIST, ticks, slot);
    end else begin
      send_request(REQ_UNKNOWN, ticks, slot);
    end
  endtask

  // empty table: list, removes, zero time, unknown request
  task automatic test_empty_table();
    send_request(REQ_LIST, '1, '1);
    send_request(REQ_REMOVE, '1, '0);
    send_request(REQ_REMOVE, '0, '1);
    send_request(REQ_RECORD, '0, '1);
    send_request(REQ_UNKNOWN, '1, '1);
  endtask

  // ordering, ties go after equal times, removal from the middle
  task automatic test_record_order();
    send_request(REQ_RECORD, 32'hFFFF_FFFF, '0);
    send_request(REQ_RECORD, 32'd1, '0);
    send_request(REQ_RECORD, 32'h8000_0000, '1);
    send_request(REQ_RECORD, 32'd1, '0);
    send_request(REQ_LIST, '0, '0);
    send_request(REQ_REMOVE, '0, 4'd1);
    send_request(REQ_REMOVE, '0, 4'd3);
    send_request(REQ_LIST, '0, '0);
  endtask

  task automatic test_disabled();
    wait_idle();
    write_stats(1'b0);
    send_request(REQ_RECORD, 32'd5, '0);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_LIST, '0, '0);
    send_request(REQ_UNKNOWN, '0, '0);
    wait_idle();
    write_stats(1'b1);
    send_request(REQ_LIST, '0, '0);
  endtask

  // fill every slot, then a time worse than all of them
  task automatic test_fill_table();
    gap_pct = 23;
    stall_pct = 23;
    repeat (18) send_request(REQ_RECORD, $urandom_range(5000, 1), SLOT_W'($urandom));
    send_request(REQ_RECORD, 32'hFFFF_FFFF, SLOT_W'($urandom));
    send_request(REQ_LIST, $urandom, SLOT_W'($urandom));
  endtask

  // receiver holds off while long lists keep coming
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (4) begin
      send_request(REQ_LIST, $urandom, SLOT_W'($urandom));
      send_request(REQ_RECORD, $urandom_range(3000, 1), SLOT_W'($urandom));
      send_request(REQ_LIST, $urandom, SLOT_W'($urandom));
    end
  endtask

  task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                  input int count);
    gap_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_random();
  endtask

  task automatic test_random_disabled();
    wait_idle();
    write_stats(1'b0);
    repeat (6) send_random();
    wait_idle();
    write_stats(1'b1);
  endtask

  initial begin
    int i;
    int spin;
    rst_n                = 1'b0;
    rx_hold              = 1'b0;
    gap_pct              = 0;
    stall_pct            = 0;
    bad_count            = 0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_LIST;
    in_ch.tick_count     = '0;
    in_ch.slot_index     = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.stats_enabled = 1'b1;
    for (i = 0; i < SBT_DEPTH; i++) begin
      best_time[i] = '0;
      best_attempt[i] = '0;
    end
    attempt_count = '0;
    stats_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_record_order();
    test_disabled();
    test_fill_table();
    test_backpressure();
    run_random_phase(0, 0, 18);
    run_random_phase(56, 0, 18);
    test_random_disabled();
    run_random_phase(0, 56, 18);
    run_random_phase(23, 23, 18);

    in_ch.valid <= 1'b0;
    for (spin = 0; spin < 20000 && due_replies.size() != 0; spin++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_replies.size() != 0) note_bad("items never seen", due_replies.size(), '0);
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sorted_best_times_table.f
src/sbt_pkg.sv
src/sbt_in_if.sv
src/sbt_out_if.sv
src/sbt_cfg_if.sv
src/sbt_ram.sv
src/sorted_best_times_table.sv
tb/sv/sorted_best_times_table_tb.sv
